### rtl/core/sdtq_pkg.sv
// Package: types and constants shared by the sorted deadline timer queue.
`default_nettype none
package sdtq_pkg;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MaxExp   = 16;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_RESERVE = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_MODIFY  = 3'd3,
    CMD_CHECK   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_NOFREE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    EV_RESERVED = 3'd0,
    EV_RELEASED = 3'd1,
    EV_MODIFIED = 3'd2,
    EV_CHECKED  = 3'd3,
    EV_EXPIRED  = 3'd4
  } event_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD_WR,
    S_CHK,
    S_INS_RD,
    S_INS_CMP,
    S_TK_HEAD,
    S_TK_CMP
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] task_id;
    logic [31:0] delay;
    logic        repeat_req;
    logic [3:0]  timer_id;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  event_res;
    logic [3:0]  slot_id;
    logic [15:0] owner_task;
    logic [31:0] remaining;
    logic        last;
  } res_t;

  // One timer record in the slot memory
  typedef struct packed {
    logic [TimeW-1:0] expiry;
    logic [TimeW-1:0] period;
    logic [15:0]      owner;
  } timer_t;

  // Edit request to the deadline order list
  typedef struct packed {
    logic             rm_en;
    logic             ins_en;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] pos;
  } ord_ctl_t;

endpackage
`default_nettype wire

### rtl/core/sorted_deadline_timer_queue_unit.sv
// Top level: command sequencer, slot occupancy, tick counter and result register.
// Results: reserve, release and unknown-id results are registered at accept; check
//   and modify results come from S_CHK or S_MOD_WR. Reserve and modify then stay busy
//   for the insert scan (S_INS_RD, S_INS_CMP). Tick: S_TK_HEAD and S_TK_CMP for each
//   head inspection, plus the insert scan per re-armed timer. Results cannot be stalled.
// Reset: asynchronous, active low; time zero, all slots free, empty order list.
`default_nettype none
module sorted_deadline_timer_queue_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire sdtq_pkg::item_t item_i,
  output logic                 res_valid_o,
  output sdtq_pkg::res_t       res_o
);
  import sdtq_pkg::*;

  state_e state_q, state_d;

  logic [TimeW-1:0]    now_q, now_d;
  logic [NumSlots-1:0] used_q, used_d;
  logic [31:0]         dly_q, dly_d;
  logic                rep_q, rep_d;
  logic                tick_q, tick_d;
  logic [TimeW-1:0]    e_q, e_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [CountW-1:0]   p_q, p_d;
  logic [CountW-1:0]   n_q, n_d;
  res_t                pend_q, pend_d;
  res_t                res_q, res_d;
  logic                res_v_q, res_v_d;

  logic             ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  timer_t           ram_wdata, ram_rdata;

  ord_ctl_t          ord_ctl;
  logic [SlotW-1:0]  ord_rd_slot, ord_head;
  logic [CountW-1:0] ord_count;

  logic             free_any;
  logic [SlotW-1:0] free_idx;
  logic             known;
  logic             accept;
  logic             ins_done;
  logic             tk_due;

  function automatic res_t mk_res(logic [1:0] st, logic [2:0] ev, logic [SlotW-1:0] s,
                                  logic [15:0] own, logic [31:0] rem, logic lst);
    res_t r;
    r.status     = st;
    r.event_res  = ev;
    r.slot_id    = s;
    r.owner_task = own;
    r.remaining  = rem;
    r.last       = lst;
    return r;
  endfunction

  sdtq_ram #(
    .Width($bits(timer_t)),
    .Depth(NumSlots)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sdtq_order u_order (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ord_ctl),
    .rd_pos_i (p_q[SlotW-1:0]),
    .rd_slot_o(ord_rd_slot),
    .head_o   (ord_head),
    .count_o  (ord_count)
  );

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign known       = used_q[item_i.timer_id];
  assign ins_done    = (p_q == ord_count) ||
                       ((state_q == S_INS_CMP) && !(ram_rdata.expiry < e_q));
  assign tk_due      = !(now_q < ram_rdata.expiry);

  // Lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            CMD_TICK:    state_d = S_TK_HEAD;
            CMD_RESERVE: state_d = free_any ? S_INS_RD : S_IDLE;
            CMD_MODIFY:  state_d = known ? S_MOD_WR : S_IDLE;
            CMD_CHECK:   state_d = known ? S_CHK : S_IDLE;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_MOD_WR: state_d = S_INS_RD;
      S_CHK:    state_d = S_IDLE;
      S_INS_RD: begin
        if (p_q == ord_count) begin
          state_d = tick_q ? S_TK_HEAD : S_IDLE;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (ins_done) begin
          state_d = tick_q ? S_TK_HEAD : S_IDLE;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_TK_HEAD: begin
        if ((n_q == CountW'(MaxExp)) || (ord_count == '0)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_TK_CMP;
        end
      end
      S_TK_CMP: begin
        if (!tk_due) begin
          state_d = S_IDLE;
        end else if (ram_rdata.period != '0) begin
          state_d = S_INS_RD;
        end else begin
          state_d = S_TK_HEAD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    now_d     = now_q;
    used_d    = used_q;
    dly_d     = dly_q;
    rep_d     = rep_q;
    tick_d    = tick_q;
    e_d       = e_q;
    slot_d    = slot_q;
    p_d       = p_q;
    n_d       = n_q;
    pend_d    = pend_q;
    res_d     = res_q;
    res_v_d   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = ram_rdata;
    ram_raddr = ord_rd_slot;
    ord_ctl   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          dly_d  = item_i.delay;
          rep_d  = item_i.repeat_req;
          tick_d = (item_i.cmd == CMD_TICK);
          slot_d = item_i.timer_id;
          n_d    = '0;
          p_d    = '0;
          ram_raddr = item_i.timer_id;
          case (item_i.cmd)
            CMD_TICK: now_d = now_q + TimeW'(1);
            CMD_RESERVE: begin
              res_v_d = 1'b1;
              if (free_any) begin
                slot_d           = free_idx;
                used_d[free_idx] = 1'b1;
                e_d              = now_q + item_i.delay;
                ram_we           = 1'b1;
                ram_waddr        = free_idx;
                ram_wdata.expiry = now_q + item_i.delay;
                ram_wdata.period = item_i.repeat_req ? item_i.delay : '0;
                ram_wdata.owner  = item_i.task_id;
                res_d = mk_res(ST_OK, EV_RESERVED, free_idx, '0, '0, 1'b1);
              end else begin
                res_d = mk_res(ST_NOFREE, EV_RESERVED, '0, '0, '0, 1'b1);
              end
            end
            CMD_RELEASE: begin
              res_v_d = 1'b1;
              if (known) begin
                ord_ctl.rm_en           = 1'b1;
                ord_ctl.slot            = item_i.timer_id;
                used_d[item_i.timer_id] = 1'b0;
                res_d = mk_res(ST_OK, EV_RELEASED, item_i.timer_id, '0, '0, 1'b1);
              end else begin
                res_d = mk_res(ST_UNKNOWN, EV_RELEASED, item_i.timer_id, '0, '0, 1'b1);
              end
            end
            CMD_MODIFY: begin
              if (known) begin
                ord_ctl.rm_en = 1'b1;
                ord_ctl.slot  = item_i.timer_id;
              end else begin
                res_v_d = 1'b1;
                res_d = mk_res(ST_UNKNOWN, EV_MODIFIED, item_i.timer_id, '0, '0, 1'b1);
              end
            end
            CMD_CHECK: begin
              if (!known) begin
                res_v_d = 1'b1;
                res_d = mk_res(ST_UNKNOWN, EV_CHECKED, item_i.timer_id, '0, '0, 1'b1);
              end
            end
            default: ;
          endcase
        end
      end

      // Re-arm the modified slot, keeping owner and possibly period
      S_MOD_WR: begin
        e_d              = now_q + dly_q;
        ram_we           = 1'b1;
        ram_wdata.expiry = now_q + dly_q;
        ram_wdata.period = rep_q ? dly_q : ram_rdata.period;
        ram_wdata.owner  = ram_rdata.owner;
        res_v_d = 1'b1;
        res_d   = mk_res(ST_OK, EV_MODIFIED, slot_q, '0, '0, 1'b1);
      end

      S_CHK: begin
        res_v_d = 1'b1;
        res_d   = mk_res(ST_OK, EV_CHECKED, slot_q, ram_rdata.owner,
                         (ram_rdata.expiry > now_q) ? (ram_rdata.expiry - now_q) : '0,
                         1'b1);
      end

      // Insert scan: first entry whose deadline is not below the new one
      S_INS_RD: begin
        if (p_q == ord_count) begin
          ord_ctl.ins_en = 1'b1;
          ord_ctl.slot   = slot_q;
          ord_ctl.pos    = p_q[SlotW-1:0];
        end
      end

      S_INS_CMP: begin
        if (ins_done) begin
          ord_ctl.ins_en = 1'b1;
          ord_ctl.slot   = slot_q;
          ord_ctl.pos    = p_q[SlotW-1:0];
        end else begin
          p_d = p_q + CountW'(1);
        end
      end

      // Look at the head of the list, or close out the tick
      S_TK_HEAD: begin
        ram_raddr = ord_head;
        if ((n_q == CountW'(MaxExp)) || (ord_count == '0)) begin
          if (n_q != '0) begin
            res_v_d     = 1'b1;
            res_d       = pend_q;
            res_d.last  = 1'b1;
          end
        end
      end

      // Expire the head if due; the previous expiry is released as not last
      S_TK_CMP: begin
        if (!tk_due) begin
          if (n_q != '0) begin
            res_v_d    = 1'b1;
            res_d      = pend_q;
            res_d.last = 1'b1;
          end
        end else begin
          if (n_q != '0) begin
            res_v_d = 1'b1;
            res_d   = pend_q;
          end
          pend_d = mk_res(ST_OK, EV_EXPIRED, ord_head, ram_rdata.owner, '0, 1'b0);
          n_d    = n_q + CountW'(1);
          ord_ctl.rm_en = 1'b1;
          ord_ctl.slot  = ord_head;
          if (ram_rdata.period != '0) begin
            slot_d           = ord_head;
            e_d              = now_q + ram_rdata.period;
            p_d              = '0;
            ram_we           = 1'b1;
            ram_waddr        = ord_head;
            ram_wdata.expiry = now_q + ram_rdata.period;
          end else begin
            used_d[ord_head] = 1'b0;
          end
        end
      end

      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      used_q  <= '0;
      n_q     <= '0;
      res_v_q <= 1'b0;
      tick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      used_q  <= used_d;
      n_q     <= n_d;
      res_v_q <= res_v_d;
      tick_q  <= tick_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dly_q  <= dly_d;
    rep_q  <= rep_d;
    e_q    <= e_d;
    slot_q <= slot_d;
    p_q    <= p_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

endmodule
`default_nettype wire

### rtl/core/sdtq_ram.sv
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none
module sdtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/core/sdtq_order.sv
// Deadline order list: slot ids sorted by expiry, with remove and insert-at-position.
`default_nettype none
module sdtq_order (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sdtq_pkg::ord_ctl_t        ctl_i,
  input  wire logic [sdtq_pkg::SlotW-1:0] rd_pos_i,
  output logic      [sdtq_pkg::SlotW-1:0] rd_slot_o,
  output logic      [sdtq_pkg::SlotW-1:0] head_o,
  output logic      [sdtq_pkg::CountW-1:0] count_o
);
  import sdtq_pkg::*;

  logic [SlotW-1:0]  order_q [NumSlots];
  logic [SlotW-1:0]  order_d [NumSlots];
  logic [CountW-1:0] count_q, count_d;
  logic [NumSlots-1:0] after;

  assign rd_slot_o = order_q[rd_pos_i];
  assign head_o    = order_q[0];
  assign count_o   = count_q;

  // Positions at or behind the removed entry shift toward the head
  always_comb begin
    after[0] = (order_q[0] == ctl_i.slot) && (count_q != '0);
    for (int i = 1; i < NumSlots; i++) begin
      after[i] = after[i-1] ||
                 ((order_q[i] == ctl_i.slot) && (CountW'(i) < count_q));
    end
  end

  // Next list contents
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < NumSlots; i++) begin
      order_d[i] = order_q[i];
    end
    if (ctl_i.rm_en) begin
      for (int i = 0; i < NumSlots - 1; i++) begin
        if (after[i]) begin
          order_d[i] = order_q[i+1];
        end
      end
      if (after[NumSlots-1]) begin
        count_d = count_q - CountW'(1);
      end
    end else if (ctl_i.ins_en) begin
      for (int i = 1; i < NumSlots; i++) begin
        if (SlotW'(i) > ctl_i.pos) begin
          order_d[i] = order_q[i-1];
        end
      end
      order_d[ctl_i.pos] = ctl_i.slot;
      count_d = count_q + CountW'(1);
    end
  end

  // Entries are only read below the count, so they need no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumSlots; i++) begin
      order_q[i] <= order_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire
